/* hdl/tcw_pkg.sv */
// shared types, codes and constants for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    // default geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // request modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // control characters
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    localparam int TAB_STEPS = 4;

    // colour after reset and the blank cell the store holds after reset
    localparam logic [7:0]  TEXT_COLOR_RESET = 8'd241;
    localparam logic [15:0] RESET_BLANK      = {TEXT_COLOR_RESET, BLANK_CHAR};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_RESP
    } tcw_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic cap_req;
        logic exec;
        logic cap_cell;
        logic copy_step;
        logic fill_blank;
        logic fill_reset;
        logic load_rsp;
    } tcw_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_read;
        logic is_clear;
        logic need_scroll;
        logic copy_end;
        logic sweep_last;
    } tcw_status_t;

endpackage

/* hdl/tcw_ctrl.sv */
// controller state machine for the text console writer
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    input  tcw_status_t status,
    output tcw_cmd_t    cmd
);

    tcw_state_t state_reg;
    tcw_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.is_clear)
                    state_next = ST_CLEAR;
                else if (status.is_read)
                    state_next = ST_READ;
                else if (status.need_scroll)
                    state_next = ST_SCROLL;
                else if (out_free)
                    state_next = ST_IDLE;
                else
                    state_next = ST_RESP;
            end
            ST_READ:
            begin
                state_next = ST_RESP;
            end
            ST_SCROLL:
            begin
                if (status.copy_end)
                    state_next = ST_BLANK;
            end
            ST_BLANK, ST_CLEAR:
            begin
                if (status.sweep_last)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_reset = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.cap_req = req_valid;
            end
            ST_EXEC:
            begin
                cmd.exec     = 1'b1;
                cmd.load_rsp = !status.is_clear && !status.is_read &&
                               !status.need_scroll && out_free;
            end
            ST_READ:
            begin
                cmd.cap_cell = 1'b1;
            end
            ST_SCROLL:
            begin
                cmd.copy_step = 1'b1;
            end
            ST_BLANK, ST_CLEAR:
            begin
                cmd.fill_blank = 1'b1;
            end
            ST_RESP:
            begin
                cmd.load_rsp = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign rsp_valid_next = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

/* hdl/tcw_datapath.sv */
// cursor logic, screen store and result registers of the text console writer
`timescale 1ns / 1ps

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [6:0]  column_in,
    input  logic [4:0]  row_in,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  tcw_cmd_t    cmd,
    output tcw_status_t status,
    output logic [10:0] cursor_position,
    output logic [15:0] cell_value,
    output logic        scrolled
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_STOP  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

    // screen store
    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_wdata;

    // control state
    logic [COL_W-1:0]  cursor_col_reg,  cursor_col_next;
    logic [ROW_W-1:0]  cursor_row_reg,  cursor_row_next;
    logic [7:0]        text_color_reg,  text_color_next;
    logic [ADDR_W-1:0] sweep_reg,       sweep_next;
    logic              copy_pending_reg, copy_pending_next;

    // request and result holding
    logic [1:0]        req_mode_reg;
    logic [7:0]        req_char_reg;
    logic [COL_W-1:0]  req_col_reg;
    logic [ROW_W-1:0]  req_row_reg;
    logic [ADDR_W-1:0] copy_addr_reg;
    logic              scroll_flag_reg;
    logic [15:0]       cell_hold_reg;
    logic [10:0]       cursor_position_reg;
    logic [15:0]       cell_value_reg;
    logic              scrolled_reg;

    // step logic
    logic [COL_W-1:0]  col_clamp;
    logic [ROW_W-1:0]  row_clamp;
    logic [COL_W:0]    tab_sum;
    logic [COL_W:0]    col_inc;
    logic [COL_W-1:0]  new_col;
    logic [ROW_W-1:0]  new_row;
    logic              advance;
    logic              need_scroll;
    logic              cell_write;
    logic              addr_new;
    logic [15:0]       exec_wdata;
    logic [15:0]       blank;
    logic [COL_W-1:0]  sel_col;
    logic [ROW_W-1:0]  sel_row;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
    logic [ADDR_W-1:0] lin_addr;
    logic [ADDR_W-1:0] pos_lin;
    logic [ADDR_W+10:0] pos_ext;
    logic [ADDR_W:0]   copy_src;

    assign blank = {text_color_reg, BLANK_CHAR};

    // clamp incoming coordinates
    always_comb
    begin
        col_clamp = (32'(column_in) > 32'(COLUMNS - 1)) ? LAST_COL : COL_W'(column_in);
        row_clamp = (32'(row_in) > 32'(ROWS - 1)) ? LAST_ROW : ROW_W'(row_in);
    end

    // cursor update for one request
    always_comb
    begin
        tab_sum     = {1'b0, cursor_col_reg} + (COL_W + 1)'(TAB_STEPS);
        col_inc     = {1'b0, cursor_col_reg} + (COL_W + 1)'(1);
        new_col     = cursor_col_reg;
        new_row     = cursor_row_reg;
        advance     = 1'b0;
        need_scroll = 1'b0;
        cell_write  = 1'b0;
        addr_new    = 1'b0;
        exec_wdata  = {text_color_reg, req_char_reg};
        case (req_mode_reg)
            MODE_PUT:
            begin
                case (req_char_reg)
                    CH_NEWLINE:
                    begin
                        new_col = '0;
                        advance = 1'b1;
                    end
                    CH_TAB:
                    begin
                        if (tab_sum >= (COL_W + 1)'(COLUMNS))
                        begin
                            new_col = COL_W'(tab_sum - (COL_W + 1)'(COLUMNS));
                            advance = 1'b1;
                        end
                        else
                            new_col = tab_sum[COL_W-1:0];
                    end
                    CH_BACKSPACE:
                    begin
                        cell_write = 1'b1;
                        addr_new   = 1'b1;
                        exec_wdata = blank;
                        if (cursor_col_reg == '0)
                        begin
                            // wraps to the end of the row above, stays at home
                            if (cursor_row_reg != '0)
                            begin
                                new_col = LAST_COL;
                                new_row = cursor_row_reg - ROW_W'(1);
                            end
                        end
                        else
                            new_col = cursor_col_reg - COL_W'(1);
                    end
                    default:
                    begin
                        cell_write = 1'b1;
                        if (col_inc == (COL_W + 1)'(COLUMNS))
                        begin
                            new_col = '0;
                            advance = 1'b1;
                        end
                        else
                            new_col = col_inc[COL_W-1:0];
                    end
                endcase
            end
            MODE_SET:
            begin
                new_col = req_col_reg;
                new_row = req_row_reg;
            end
            MODE_CLEAR:
            begin
                new_col = '0;
                new_row = '0;
            end
            MODE_READ:
            begin
                new_col = cursor_col_reg;
            end
            default:
            begin
                new_col = cursor_col_reg;
            end
        endcase
        if (advance)
        begin
            if (cursor_row_reg == LAST_ROW)
                need_scroll = 1'b1;
            else
                new_row = cursor_row_reg + ROW_W'(1);
        end
    end

    // cell address for the step
    always_comb
    begin
        if (req_mode_reg == MODE_READ)
        begin
            sel_col = req_col_reg;
            sel_row = req_row_reg;
        end
        else if (addr_new)
        begin
            sel_col = new_col;
            sel_row = new_row;
        end
        else
        begin
            sel_col = cursor_col_reg;
            sel_row = cursor_row_reg;
        end
        // the result taken straight from the step uses the cursor it leaves
        pos_col  = cmd.exec ? new_col : cursor_col_reg;
        pos_row  = cmd.exec ? new_row : cursor_row_reg;
        lin_addr = ADDR_W'(ADDR_W'(sel_row) * ROW_STRIDE) + ADDR_W'(sel_col);
        pos_lin  = ADDR_W'(ADDR_W'(pos_row) * ROW_STRIDE) + ADDR_W'(pos_col);
        pos_ext  = {11'd0, pos_lin};
        copy_src = {1'b0, sweep_reg} + (ADDR_W + 1)'(COLUMNS);
    end

    // store port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = lin_addr;
        mem_wdata = exec_wdata;
        mem_raddr = lin_addr;
        if (cmd.fill_reset)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = RESET_BLANK;
        end
        else if (cmd.fill_blank)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = blank;
        end
        else if (copy_pending_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_addr_reg;
            mem_wdata = rdata_reg;
        end
        else if (cmd.exec && cell_write)
        begin
            mem_we = 1'b1;
        end
        if (cmd.copy_step && !status.copy_end)
            mem_raddr = ADDR_W'(copy_src);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // control state next values
    always_comb
    begin
        cursor_col_next   = cursor_col_reg;
        cursor_row_next   = cursor_row_reg;
        text_color_next   = cfg_we ? cfg_wdata : text_color_reg;
        sweep_next        = sweep_reg;
        copy_pending_next = 1'b0;
        if (cmd.cap_req)
            sweep_next = '0;
        else if (cmd.fill_reset || cmd.fill_blank)
            sweep_next = sweep_reg + ADDR_W'(1);
        else if (cmd.copy_step && !status.copy_end)
        begin
            sweep_next        = sweep_reg + ADDR_W'(1);
            copy_pending_next = 1'b1;
        end
        if (cmd.exec)
        begin
            cursor_col_next = new_col;
            cursor_row_next = need_scroll ? LAST_ROW : new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg   <= '0;
            cursor_row_reg   <= '0;
            text_color_reg   <= TEXT_COLOR_RESET;
            sweep_reg        <= '0;
            copy_pending_reg <= 1'b0;
        end
        else
        begin
            cursor_col_reg   <= cursor_col_next;
            cursor_row_reg   <= cursor_row_next;
            text_color_reg   <= text_color_next;
            sweep_reg        <= sweep_next;
            copy_pending_reg <= copy_pending_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_req)
        begin
            req_mode_reg  <= mode;
            req_char_reg  <= char_code;
            req_col_reg   <= col_clamp;
            req_row_reg   <= row_clamp;
            cell_hold_reg <= '0;
        end
        if (cmd.exec)
            scroll_flag_reg <= need_scroll;
        if (cmd.copy_step)
            copy_addr_reg <= sweep_reg;
        if (cmd.cap_cell)
            cell_hold_reg <= rdata_reg;
        if (cmd.load_rsp)
        begin
            cursor_position_reg <= pos_ext[10:0];
            cell_value_reg      <= cell_hold_reg;
            scrolled_reg        <= cmd.exec ? need_scroll : scroll_flag_reg;
        end
    end

    always_comb
    begin
        status.is_read     = (req_mode_reg == MODE_READ);
        status.is_clear    = (req_mode_reg == MODE_CLEAR);
        status.need_scroll = need_scroll;
        status.copy_end    = (sweep_reg == COPY_STOP);
        status.sweep_last  = (sweep_reg == LAST_CELL);
    end

    assign cursor_position = cursor_position_reg;
    assign cell_value      = cell_value_reg;
    assign scrolled        = scrolled_reg;

endmodule

/* hdl/text_console_writer.sv */
// text console writer top level: controller, datapath and checks
// a request is captured in idle and executed; put (no scroll) and set register their result
// from the execute step, or from a result step while the last result is still held; read adds
// a read step, clear a sweep blanking every cell, a scroll a row copy then blanking of the last
// row; no new request is taken until the last is through, clear and scroll for their whole sweep
// reset: cursor to 0,0, colour 0xF1, then a clearing pass writes every cell blank
// while req_ready stays low
`timescale 1ns / 1ps

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [6:0]  column_in,
    input  logic [4:0]  row_in,
    // result channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [10:0] cursor_position,
    output logic [15:0] cell_value,
    output logic        scrolled,
    // colour register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    // sequencing: one request at a time, the result register frees the request side
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // cursor arithmetic, screen store and sweep counter
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode),
        .char_code       (char_code),
        .column_in       (column_in),
        .row_in          (row_in),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .status          (status),
        .cursor_position (cursor_position),
        .cell_value      (cell_value),
        .scrolled        (scrolled)
    );

    // only one source drives the store write port in any cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec, cmd.copy_step, cmd.fill_blank, cmd.fill_reset}))
        else $error("more than one store writer active");

    // a request in progress blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in progress");

    // no request is taken during a sweep of the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill_reset || cmd.fill_blank || cmd.copy_step) |-> !req_ready)
        else $error("request port open during a store sweep");

endmodule
